/* rtl/cpid_pkg.sv */
// Shared types and constants of the cascaded PID step unit.
// Depends on nothing; used by every module of the block.
`default_nettype none

package cpid_pkg;

  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned CEIL_W      = 31;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 31;
  localparam int unsigned OPND_W      = 32;
  localparam int unsigned PROD_W      = 40;  // product after the Q8.8 shift

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OUTER_KP   = 3'd0,
    CFG_OUTER_KI   = 3'd1,
    CFG_OUTER_KD   = 3'd2,
    CFG_INNER_KP   = 3'd3,
    CFG_INNER_KI   = 3'd4,
    CFG_INNER_KD   = 3'd5,
    CFG_ERR_CEIL   = 3'd6,
    CFG_INT_CEIL   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] outer_kp;
    logic [GAIN_W-1:0] outer_ki;
    logic [GAIN_W-1:0] outer_kd;
    logic [GAIN_W-1:0] inner_kp;
    logic [GAIN_W-1:0] inner_ki;
    logic [GAIN_W-1:0] inner_kd;
    logic [GAIN_W-1:0] err_ceil;
    logic [CEIL_W-1:0] int_ceil;
  } cfg_t;

  localparam logic [GAIN_W-1:0] RST_OUTER_KP = 16'd7680;
  localparam logic [GAIN_W-1:0] RST_OUTER_KI = 16'd256;
  localparam logic [GAIN_W-1:0] RST_OUTER_KD = 16'd1536;
  localparam logic [GAIN_W-1:0] RST_INNER_KP = 16'd7680;
  localparam logic [GAIN_W-1:0] RST_INNER_KI = 16'd205;
  localparam logic [GAIN_W-1:0] RST_INNER_KD = 16'd1536;
  localparam logic [GAIN_W-1:0] RST_ERR_CEIL = 16'd3;
  localparam logic [CEIL_W-1:0] RST_INT_CEIL = 31'd300;

endpackage

`default_nettype wire

/* rtl/cascade_pid_step_unit.sv */
// Cascaded PID step unit: each item (target, measured) yields one outer and
// one inner drive. The six gain products run one after another on a single
// bit-serial multiplier that takes one gain bit per cycle, and the block
// accepts a new item only in its idle state, after the last one has reached
// the output register. A finished result waits in the output register while
// the next item is accepted. Write configuration only while no item is in
// flight.
// Depends on cpid_pkg, cpid_cfg_regs and cpid_serial_mul.
`default_nettype none

module cascade_pid_step_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [15:0]                  target_i,
  input  wire logic signed [15:0]                  measured_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [31:0]                       outer_drive_o,
  output logic signed [31:0]                       inner_drive_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [cpid_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [cpid_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ERR  = 7'b0000010,
    ST_INT  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_WAIT = 7'b0010000,
    ST_SAT  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_e;

  localparam logic LOOP_OUTER = 1'b0;
  localparam logic LOOP_INNER = 1'b1;

  function automatic logic signed [31:0] sat32_of42(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v[41:31] == {11{v[41]}}) r = v[31:0];
    else r = v[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32_of33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] == v[31]) r = v[31:0];
    else r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16_of32(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v[31:15] == {17{v[31]}}) r = v[15:0];
    else r = v[31] ? 16'sh8000 : 16'sh7FFF;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16_of19(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v[18:15] == {4{v[18]}}) r = v[15:0];
    else r = v[18] ? 16'sh8000 : 16'sh7FFF;
    return r;
  endfunction

  cpid_pkg::cfg_t cfg;

  state_e state_q, state_d;
  term_e  term_q, term_d;
  logic   loop_q, loop_d;
  logic   out_valid_q, out_valid_d;

  logic signed [15:0] tgt_q, meas_q;
  logic signed [17:0] e_q, oerr_q, ierr_q;
  logic signed [18:0] de_q;
  logic signed [31:0] s_q, osum_q, isum_q, dout_q;
  logic signed [41:0] dacc_q;
  logic signed [31:0] odrv_q, idrv_q;

  logic                             mul_start, mul_done;
  logic [cpid_pkg::GAIN_W-1:0]      mul_gain;
  logic signed [cpid_pkg::OPND_W-1:0] mul_opnd;
  logic signed [cpid_pkg::PROD_W-1:0] mul_prod;

  logic signed [16:0] ediff, ie17;
  logic signed [17:0] oe, ie, e_new, perr;
  logic signed [18:0] de_new;
  logic signed [15:0] ti, mi;
  logic signed [31:0] psum_prev, ssat, s_new;
  logic signed [32:0] sum33;
  logic signed [31:0] ceil32;

  cpid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cpid_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .gain_i    (mul_gain),
    .operand_i (mul_opnd),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  // error and error change for the loop in progress
  always_comb begin
    ediff  = {tgt_q[15], tgt_q} - {meas_q[15], meas_q};
    oe     = ($signed({ediff[16], ediff}) > $signed({2'b00, cfg.err_ceil}))
             ? $signed({2'b00, cfg.err_ceil}) : {ediff[16], ediff};
    ti     = sat16_of32(dout_q);
    mi     = sat16_of19(de_q);
    ie17   = {ti[15], ti} - {mi[15], mi};
    ie     = {ie17[16], ie17};
    e_new  = (loop_q == LOOP_INNER) ? ie : oe;
    perr   = (loop_q == LOOP_INNER) ? ierr_q : oerr_q;
    de_new = {e_new[17], e_new} - {perr[17], perr};
  end

  // integral: saturate, then clamp from above
  always_comb begin
    ceil32    = $signed({1'b0, cfg.int_ceil});
    psum_prev = (loop_q == LOOP_INNER) ? isum_q : osum_q;
    sum33     = {psum_prev[31], psum_prev} + {{15{e_q[17]}}, e_q};
    ssat      = sat32_of33(sum33);
    s_new     = (ssat > ceil32) ? ceil32 : ssat;
  end

  always_comb begin
    case (term_q)
      TERM_P:  mul_opnd = {{14{e_q[17]}}, e_q};
      TERM_I:  mul_opnd = s_q;
      TERM_D:  mul_opnd = {{13{de_q[18]}}, de_q};
      default: mul_opnd = '0;
    endcase
    case (term_q)
      TERM_P:  mul_gain = (loop_q == LOOP_INNER) ? cfg.inner_kp : cfg.outer_kp;
      TERM_I:  mul_gain = (loop_q == LOOP_INNER) ? cfg.inner_ki : cfg.outer_ki;
      TERM_D:  mul_gain = (loop_q == LOOP_INNER) ? cfg.inner_kd : cfg.outer_kd;
      default: mul_gain = '0;
    endcase
  end

  assign mul_start  = (state_q == ST_MUL);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    loop_d      = loop_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ERR;
          loop_d  = LOOP_OUTER;
        end
      end
      ST_ERR: begin
        state_d = ST_INT;
        term_d  = TERM_P;
      end
      ST_INT:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          case (term_q)
            TERM_P: begin
              term_d  = TERM_I;
              state_d = ST_MUL;
            end
            TERM_I: begin
              term_d  = TERM_D;
              state_d = ST_MUL;
            end
            default: state_d = ST_SAT;
          endcase
        end
      end
      ST_SAT: begin
        if (loop_q == LOOP_OUTER) begin
          loop_d  = LOOP_INNER;
          state_d = ST_ERR;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_P;
      loop_q      <= LOOP_OUTER;
      out_valid_q <= 1'b0;
      oerr_q      <= '0;
      osum_q      <= '0;
      ierr_q      <= '0;
      isum_q      <= '0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      loop_q      <= loop_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_INT) begin
        if (loop_q == LOOP_INNER) begin
          ierr_q <= e_q;
          isum_q <= s_new;
        end else begin
          oerr_q <= e_q;
          osum_q <= s_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tgt_q  <= target_i;
      meas_q <= measured_i;
    end
    if (state_q == ST_ERR) begin
      e_q    <= e_new;
      de_q   <= de_new;
      dacc_q <= '0;
    end
    if (state_q == ST_INT) s_q <= s_new;
    if (state_q == ST_WAIT && mul_done) begin
      dacc_q <= dacc_q + {{2{mul_prod[cpid_pkg::PROD_W-1]}}, mul_prod};
    end
    if (state_q == ST_SAT && loop_q == LOOP_OUTER) dout_q <= sat32_of42(dacc_q);
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      odrv_q <= dout_q;
      idrv_q <= sat32_of42(dacc_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outer_drive_o = odrv_q;
  assign inner_drive_o = idrv_q;

  a_accept_starts_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_ERR && loop_q == LOOP_OUTER))
    else $error("accepted item did not start the outer loop");

  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_WAIT))
    else $error("multiplier finished outside the wait state");

  a_term_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (term_q == TERM_P || term_q == TERM_I || term_q == TERM_D))
    else $error("product index out of range");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result presented outside the output state");

  a_inner_after_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (loop_q == LOOP_INNER))
    else $error("result stage reached without the inner loop");

endmodule

`default_nettype wire

/* rtl/cpid_cfg_regs.sv */
// Configuration register bank of the cascaded PID step unit.
// Depends on cpid_pkg for the register indexes and the cfg_t layout.
`default_nettype none

module cpid_cfg_regs (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [cpid_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire logic [cpid_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output cpid_pkg::cfg_t                             cfg_o
);

  cpid_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outer_kp <= cpid_pkg::RST_OUTER_KP;
      cfg_q.outer_ki <= cpid_pkg::RST_OUTER_KI;
      cfg_q.outer_kd <= cpid_pkg::RST_OUTER_KD;
      cfg_q.inner_kp <= cpid_pkg::RST_INNER_KP;
      cfg_q.inner_ki <= cpid_pkg::RST_INNER_KI;
      cfg_q.inner_kd <= cpid_pkg::RST_INNER_KD;
      cfg_q.err_ceil <= cpid_pkg::RST_ERR_CEIL;
      cfg_q.int_ceil <= cpid_pkg::RST_INT_CEIL;
    end else if (cfg_we_i) begin
      case (cpid_pkg::cfg_idx_e'(cfg_index_i))
        cpid_pkg::CFG_OUTER_KP: cfg_q.outer_kp <= cfg_data_i[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::CFG_OUTER_KI: cfg_q.outer_ki <= cfg_data_i[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::CFG_OUTER_KD: cfg_q.outer_kd <= cfg_data_i[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::CFG_INNER_KP: cfg_q.inner_kp <= cfg_data_i[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::CFG_INNER_KI: cfg_q.inner_ki <= cfg_data_i[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::CFG_INNER_KD: cfg_q.inner_kd <= cfg_data_i[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::CFG_ERR_CEIL: cfg_q.err_ceil <= cfg_data_i[cpid_pkg::GAIN_W-1:0];
        cpid_pkg::CFG_INT_CEIL: cfg_q.int_ceil <= cfg_data_i[cpid_pkg::CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/cpid_serial_mul.sv */
// Bit-serial multiplier: unsigned Q8.8 gain times signed 32-bit operand,
// one gain bit per cycle, result floored by 8 bits. Depends on cpid_pkg.
`default_nettype none

module cpid_serial_mul (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic        [cpid_pkg::GAIN_W-1:0]    gain_i,
  input  wire logic signed [cpid_pkg::OPND_W-1:0]    operand_i,
  output logic                                       done_o,
  output logic signed      [cpid_pkg::PROD_W-1:0]    product_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [3:0]                      cnt_q, cnt_d;
  logic [cpid_pkg::GAIN_W-1:0]     gain_q, gain_d;
  logic signed [cpid_pkg::OPND_W-1:0] opnd_q, opnd_d;
  logic signed [cpid_pkg::OPND_W:0]   acc_q, acc_d;
  logic [cpid_pkg::GAIN_W-1:0]     low_q, low_d;

  logic signed [cpid_pkg::OPND_W+1:0] addend;
  logic signed [cpid_pkg::OPND_W+1:0] psum;

  always_comb begin
    addend = gain_q[0] ? {opnd_q[cpid_pkg::OPND_W-1], opnd_q[cpid_pkg::OPND_W-1], opnd_q}
                       : '0;
    psum   = {acc_q[cpid_pkg::OPND_W], acc_q} + addend;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    gain_d = gain_q;
    opnd_d = opnd_q;
    acc_d  = acc_q;
    low_d  = low_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      gain_d = gain_i;
      opnd_d = operand_i;
      acc_d  = '0;
      low_d  = '0;
    end else if (busy_q) begin
      // add, then shift the partial product right; low bits drop into low_q
      acc_d  = psum[cpid_pkg::OPND_W+1:1];
      low_d  = {psum[0], low_q[cpid_pkg::GAIN_W-1:1]};
      gain_d = {1'b0, gain_q[cpid_pkg::GAIN_W-1:1]};
      cnt_d  = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
    opnd_q <= opnd_d;
    acc_q  <= acc_d;
    low_q  <= low_d;
  end

  // product = acc * 2^16 + low, so the floor by 8 bits is a plain select
  assign product_o = {acc_q[cpid_pkg::OPND_W-1:0], low_q[cpid_pkg::GAIN_W-1:8]};
  assign done_o    = done_q;

endmodule

`default_nettype wire
